// ===== rtl/wav_pkg.sv =====
// Package for the monochrome bitmap raster writer.
// Holds the word types, command codes, header layout and the state type.
// No dependencies.
package wav_pkg;

    localparam int N_W = 11;
    localparam int ROW_W = 12;
    localparam int COLB_W = 8;
    localparam int RB_W = 9;
    localparam int HALF_W = 10;
    localparam int SIZE_W = 20;
    localparam int HDR_BYTES = 62;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_FETCH = 2'd1;
    localparam logic [1:0] CMD_REWIND = 2'd2;

    localparam logic [5:0] HDR_SIZE0 = 6'd2;
    localparam logic [5:0] HDR_SIZE1 = 6'd3;
    localparam logic [5:0] HDR_SIZE2 = 6'd4;
    localparam logic [5:0] HDR_SIZE3 = 6'd5;
    localparam logic [5:0] HDR_WID_LO = 6'd18;
    localparam logic [5:0] HDR_WID_HI = 6'd19;
    localparam logic [5:0] HDR_HGT_LO = 6'd22;
    localparam logic [5:0] HDR_HGT_HI = 6'd23;

    typedef struct packed {
        logic [1:0]          command;
        logic signed [15:0]  sample_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_PIX
    } t_state;

    function automatic logic [7:0] hdr_byte(input logic [5:0] idx);
        logic [7:0] b;
        case (idx)
            6'd0:    b = 8'h42;
            6'd1:    b = 8'h4d;
            6'd10:   b = 8'h3e;
            6'd14:   b = 8'h28;
            6'd26:   b = 8'h01;
            6'd28:   b = 8'h01;
            6'd38:   b = 8'h61;
            6'd39:   b = 8'h0f;
            6'd42:   b = 8'h61;
            6'd43:   b = 8'h0f;
            6'd55:   b = 8'hff;
            6'd56:   b = 8'hee;
            6'd57:   b = 8'hff;
            6'd58:   b = 8'hff;
            6'd60:   b = 8'h11;
            6'd61:   b = 8'hff;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/waveform_to_mono_bmp_raster.sv =====
// Top level of the monochrome bitmap raster writer.
// Holds the column memory, geometry registers and the command sequencer.
// Depends on wav_pkg and wav_div.
//
// A word is taken when start is high and busy is low; results appear for one
// cycle with o_strobe and cannot be held off. A load, a rewind, an ignored
// command and a header byte fetch keep busy high for one cycle after the
// accepting edge. A pixel byte fetch keeps busy high through the command
// decode and eight reads of the column memory, one per cycle, plus its read
// latency. The first pixel fetch after a write to the size register, unless
// a rewind comes between, first runs the serial divider to locate the row
// and byte column.
module waveform_to_mono_bmp_raster
    import wav_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in_word         i_word,
    output logic             o_strobe,
    output t_out_word        o_word,
    input  logic             i_cfg_we,
    input  logic [N_W-1:0]   i_cfg_wdata
);

    localparam int NCAP  = (MAX_COLUMNS < 2047) ? MAX_COLUMNS : 2047;
    localparam int PCAP  = ((NCAP + 31) / 32) * 32;
    localparam int POS_W = $clog2(HDR_BYTES + PCAP * PCAP / 8 + 1);
    localparam int AW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    t_state r_state, n_state;

    logic [N_W-1:0]    r_num_values;
    logic [N_W-1:0]    r_n;
    logic [HALF_W-1:0] r_half;
    logic [RB_W-1:0]   r_rowbytes;
    logic [POS_W-1:0]  r_total;
    logic [SIZE_W-1:0] r_size;

    logic [1:0]        r_cmd;
    logic [15:0]       r_sample;
    logic [N_W-1:0]    r_load_idx;
    logic [POS_W-1:0]  r_pos;
    logic [ROW_W-1:0]  r_row;
    logic [COLB_W-1:0] r_colb;
    logic              r_rc_ok;
    logic [3:0]        r_k;
    logic [2:0]        r_pk;
    logic              r_hit;
    logic [7:0]        r_acc;
    logic              r_strobe;
    t_out_word         r_word;

    logic [15:0]       mem [MAX_COLUMNS];
    logic [15:0]       r_rd;

    logic [N_W-1:0]    w_n;
    logic [11:0]       w_nup;
    logic [6:0]        w_pq;
    logic [13:0]       w_pq2;
    logic [20:0]       w_tot;
    logic [21:0]       w_nsq;

    logic              w_in_file;
    logic              w_in_hdr;
    logic              w_pixel;
    logic              w_div_start;
    logic              w_mem_we;
    logic [N_W-1:0]    w_j;
    logic [AW-1:0]     w_rd_addr;
    logic [17:0]       w_target;
    logic              w_bit;
    logic [7:0]        w_acc;
    logic [7:0]        w_hdr;
    logic              w_last;
    logic [POS_W-1:0]  w_p;
    logic              w_div_done;
    logic [POS_W-1:0]  w_quot;
    logic [RB_W-1:0]   w_rem;

    // Geometry is registered from the size register and follows it in the next cycle.
    assign w_n   = (32'(r_num_values) > MAX_COLUMNS) ? N_W'(MAX_COLUMNS) : r_num_values;
    assign w_nup = {1'b0, w_n} + 12'd31;
    assign w_pq  = w_nup[11:5];
    assign w_pq2 = {7'b0, w_pq} * {7'b0, w_pq};
    assign w_tot = {w_pq2, 7'b0} + 21'(HDR_BYTES);
    assign w_nsq = {11'b0, w_n} * {11'b0, w_n};

    always_ff @(posedge i_clk) begin
        r_n        <= w_n;
        r_half     <= w_n[N_W-1:1];
        r_rowbytes <= {w_pq, 2'b00};
        r_total    <= POS_W'(w_tot);
        r_size     <= SIZE_W'(w_nsq >> 3) + SIZE_W'(HDR_BYTES);
    end

    assign w_in_file = r_pos < r_total;
    assign w_in_hdr  = r_pos < POS_W'(HDR_BYTES);
    assign w_pixel   = (r_cmd == CMD_FETCH) && w_in_file && !w_in_hdr;
    assign w_last    = r_pos == (r_total - POS_W'(1));
    assign w_p       = r_pos - POS_W'(HDR_BYTES);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_pixel) begin
                    n_state = r_rc_ok ? ST_PIX : ST_DIV;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_PIX;
                end
            end
            ST_PIX: begin
                if (r_k == 4'd8) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy        = 1'b1;
        w_div_start = 1'b0;
        w_mem_we    = 1'b0;
        case (r_state)
            ST_IDLE: busy = 1'b0;
            ST_EXEC: begin
                w_div_start = w_pixel && !r_rc_ok;
                w_mem_we    = (r_cmd == CMD_LOAD) && (r_load_idx < r_n);
            end
            default: busy = 1'b1;
        endcase
    end

    always_comb begin
        case (r_pos[5:0])
            HDR_SIZE0:  w_hdr = r_size[7:0];
            HDR_SIZE1:  w_hdr = r_size[15:8];
            HDR_SIZE2:  w_hdr = {4'b0, r_size[19:16]};
            HDR_SIZE3:  w_hdr = 8'h00;
            HDR_WID_LO: w_hdr = r_n[7:0];
            HDR_WID_HI: w_hdr = {5'b0, r_n[10:8]};
            HDR_HGT_LO: w_hdr = r_n[7:0];
            HDR_HGT_HI: w_hdr = {5'b0, r_n[10:8]};
            default:    w_hdr = hdr_byte(r_pos[5:0]);
        endcase
    end

    assign w_j       = {r_colb, r_k[2:0]};
    assign w_rd_addr = AW'(w_j);
    assign w_target  = {{2{r_rd[15]}}, r_rd} + {8'b0, r_half};
    assign w_bit     = (r_k != 4'd0) && r_hit && (w_target == {6'b0, r_row});
    assign w_acc     = r_acc | (w_bit ? (8'h80 >> r_pk) : 8'h00);

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[AW'(r_load_idx)] <= r_sample;
        end
        r_rd <= mem[w_rd_addr];
    end

    wav_div #(
        .DW(POS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_p),
        .i_divisor  (r_rowbytes),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_num_values <= N_W'(100);
            r_load_idx   <= '0;
            r_pos        <= '0;
            r_row        <= '0;
            r_colb       <= '0;
            r_rc_ok      <= 1'b1;
            r_k          <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_cmd    <= i_word.command;
                        r_sample <= i_word.sample_value;
                    end
                end
                ST_EXEC: begin
                    r_k   <= '0;
                    r_acc <= '0;
                    case (r_cmd)
                        CMD_LOAD: begin
                            if (r_load_idx < r_n) begin
                                r_load_idx <= r_load_idx + N_W'(1);
                            end
                        end
                        CMD_REWIND: begin
                            r_load_idx <= '0;
                            r_pos      <= '0;
                            r_row      <= '0;
                            r_colb     <= '0;
                            r_rc_ok    <= 1'b1;
                        end
                        CMD_FETCH: begin
                            if (w_in_file && w_in_hdr) begin
                                r_word.out_byte  <= w_hdr;
                                r_word.last_byte <= w_last;
                                r_strobe         <= 1'b1;
                                r_pos            <= r_pos + POS_W'(1);
                            end
                        end
                        default: r_k <= '0;
                    endcase
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_row   <= ROW_W'(w_quot);
                        r_colb  <= w_rem[COLB_W-1:0];
                        r_rc_ok <= 1'b1;
                    end
                end
                ST_PIX: begin
                    r_k   <= r_k + 4'd1;
                    r_acc <= w_acc;
                    r_pk  <= r_k[2:0];
                    r_hit <= w_j < r_n;
                    if (r_k == 4'd8) begin
                        r_word.out_byte  <= ({1'b0, r_row} < {2'b0, r_n}) ? w_acc : 8'h00;
                        r_word.last_byte <= w_last;
                        r_strobe         <= 1'b1;
                        r_pos            <= r_pos + POS_W'(1);
                        if ((RB_W'(r_colb) + RB_W'(1)) == r_rowbytes) begin
                            r_colb <= '0;
                            r_row  <= r_row + ROW_W'(1);
                        end else begin
                            r_colb <= r_colb + COLB_W'(1);
                        end
                    end
                end
                default: r_k <= '0;
            endcase
            if (i_cfg_we) begin
                r_num_values <= i_cfg_wdata;
                r_rc_ok      <= 1'b0;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_word   = r_word;

endmodule

// ===== rtl/wav_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Used to find the pixel row and byte column of a file position.
// Depends on wav_pkg.
module wav_div
    import wav_pkg::*;
#(
    parameter int DW = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DW-1:0]    i_dividend,
    input  logic [RB_W-1:0]  i_divisor,
    output logic             o_done,
    output logic [DW-1:0]    o_quot,
    output logic [RB_W-1:0]  o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]   r_q;
    logic [RB_W-1:0] r_rem;
    logic [CW-1:0]   r_cnt;
    logic            r_run;
    logic            r_done;
    logic [RB_W:0]   w_sh;
    logic            w_ge;

    assign w_sh = {r_rem, r_q[DW-1]};
    assign w_ge = w_sh >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(DW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_run) begin
            r_q   <= {r_q[DW-2:0], w_ge};
            r_rem <= w_ge ? RB_W'(w_sh - {1'b0, i_divisor}) : w_sh[RB_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/wav_chk.sv =====
// Port-level checker for the monochrome bitmap raster writer.
// Watches the command handshake and the result strobe; bound to the top level.
// Depends on waveform_to_mono_bmp_raster.
module wav_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Word accepted but busy did not rise.");

    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("Result strobe without a word in progress.");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("Two result strobes in consecutive cycles.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_strobe))
        else $error("Block not idle after reset.");

endmodule

bind waveform_to_mono_bmp_raster wav_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe)
);

// ===== sim/tb_waveform_to_mono_bmp_raster.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the monochrome bitmap raster writer.
// Drives loads, fetches and rewinds, and checks every returned byte against a predictor.
// Depends on wav_pkg and the waveform_to_mono_bmp_raster RTL.
module tb_waveform_to_mono_bmp_raster;
    import wav_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int RESET_CYCLES = 11;
    localparam int MAX_COLUMNS = 1024;
    localparam int SETTLE_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_WORDS = 1800;
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic [7:0] BMP_HEADER [HDR_BYTES] = '{
        8'h42, 8'h4d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h3e, 8'h00, 8'h00, 8'h00, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h61, 8'h0f,
        8'h00, 8'h00, 8'h61, 8'h0f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hee, 8'hff, 8'hff, 8'h00,
        8'h11, 8'hff
    };

    class bmp_byte_scoreboard;
        logic [15:0]    column_mem [MAX_COLUMNS];
        logic [N_W-1:0] size_reg;
        logic [N_W-1:0] load_ptr;
        logic [17:0]    byte_pos;
        int unsigned    loaded_hi;
        t_out_word      expected_bytes[$];
        int             mismatch_count;

        function new();
            size_reg = 11'd100;
            load_ptr = '0;
            byte_pos = '0;
            loaded_hi = 0;
            mismatch_count = 0;
            foreach (column_mem[i]) column_mem[i] = '0;
        endfunction

        function void set_size(logic [N_W-1:0] v);
            size_reg = v;
        endfunction

        function int unsigned columns();
            return (size_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(size_reg);
        endfunction

        function int unsigned padded(int unsigned v);
            return (v + 31) / 32 * 32;
        endfunction

        function int unsigned file_bytes();
            int unsigned pad;
            pad = padded(columns());
            return HDR_BYTES + pad * pad / 8;
        endfunction

        function int unsigned bytes_left();
            int unsigned total;
            total = file_bytes();
            return (total > byte_pos) ? total - byte_pos : 0;
        endfunction

        // A pixel fetch must not read a column that was never loaded.
        function bit fetch_is_safe();
            return loaded_hi >= columns() || byte_pos < HDR_BYTES || byte_pos >= file_bytes();
        endfunction

        function logic [7:0] header_byte(logic [5:0] idx, int unsigned n);
            int unsigned file_size;
            file_size = HDR_BYTES + n * n / 8;
            case (idx)
                HDR_SIZE0: return file_size[7:0];
                HDR_SIZE1: return file_size[15:8];
                HDR_SIZE2: return file_size[23:16];
                HDR_SIZE3: return file_size[31:24];
                HDR_WID_LO, HDR_HGT_LO: return n[7:0];
                HDR_WID_HI, HDR_HGT_HI: return n[15:8];
                default: return BMP_HEADER[idx];
            endcase
        endfunction

        function logic [7:0] pixel_byte(int unsigned p, int unsigned n);
            int unsigned row_bytes;
            int unsigned row;
            int unsigned col0;
            int unsigned j;
            logic signed [15:0] sample;
            int target;
            logic [7:0] b;
            b = '0;
            row_bytes = padded(n) / 8;
            if (row_bytes == 0) return b;
            row = p / row_bytes;
            col0 = (p % row_bytes) * 8;
            if (row >= n) return b;
            for (int k = 0; k < 8; k++) begin
                j = col0 + k;
                if (j < n) begin
                    sample = column_mem[j];
                    target = int'(sample) + int'(n / 2);
                    if (target == int'(row)) b[7-k] = 1'b1;
                end
            end
            return b;
        endfunction

        function void note_word(t_in_word w);
            int unsigned n;
            int unsigned total;
            t_out_word r;
            n = columns();
            case (w.command)
                CMD_LOAD: begin
                    if (load_ptr < n) begin
                        column_mem[load_ptr] = w.sample_value;
                        load_ptr = load_ptr + 1'b1;
                        if (load_ptr > loaded_hi) loaded_hi = load_ptr;
                    end
                end
                CMD_REWIND: begin
                    load_ptr = '0;
                    byte_pos = '0;
                end
                CMD_FETCH: begin
                    total = file_bytes();
                    if (byte_pos < total) begin
                        if (byte_pos < HDR_BYTES)
                            r.out_byte = header_byte(byte_pos[5:0], n);
                        else
                            r.out_byte = pixel_byte(byte_pos - HDR_BYTES, n);
                        r.last_byte = (byte_pos == total - 1);
                        expected_bytes.push_back(r);
                        byte_pos = byte_pos + 1'b1;
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatch_count++;
        endtask

        task check_word(t_out_word got);
            t_out_word want;
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last %0b",
                                          got.out_byte, got.last_byte));
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte %02h, expected %02h",
                                          got.out_byte, want.out_byte));
            if (got.last_byte !== want.last_byte)
                report_mismatch($sformatf("last_byte %0b, expected %0b",
                                          got.last_byte, want.last_byte));
        endtask

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    t_in_word       i_word;
    logic           o_strobe;
    t_out_word      o_word;
    logic           i_cfg_we;
    logic [N_W-1:0] i_cfg_wdata;

    bmp_byte_scoreboard sb;
    int idle_cycles;
    int words_sent;
    bit burst;
    bit with_noise;

    waveform_to_mono_bmp_raster #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_word(i_word),
        .o_strobe(o_strobe),
        .o_word(o_word),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) sb.check_word(o_word);
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start && !busy) || o_strobe || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("waveform_to_mono_bmp_raster verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(logic [1:0] cmd, logic [15:0] sample);
        t_in_word w;
        int gap;
        w.command = cmd;
        w.sample_value = sample;
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_word(w);
        words_sent++;
    endtask

    task automatic write_size(logic [N_W-1:0] v);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_size(v);
    endtask

    function automatic logic [15:0] pick_sample(int unsigned n);
        int r;
        case ($urandom_range(0, 9))
            0: return 16'($urandom());
            1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: begin
                r = $urandom_range(0, n + 1);
                return 16'(r - int'(n / 2));
            end
        endcase
    endfunction

    task automatic maybe_noise();
        logic [1:0] cmd;
        if (with_noise && $urandom_range(0, 11) == 0) begin
            cmd = 2'($urandom_range(0, 3));
            if (cmd == CMD_FETCH && !sb.fetch_is_safe()) cmd = CMD_NONE;
            send_word(cmd, 16'($urandom()));
        end
    endtask

    task automatic fetch_byte();
        if (sb.fetch_is_safe())
            send_word(CMD_FETCH, 16'($urandom()));
        else
            send_word(CMD_LOAD, pick_sample(sb.columns()));
    endtask

    task automatic run_phase(logic [N_W-1:0] size, bit new_size, bit rewind,
                             int unsigned n_loads, bit whole_file, int unsigned n_fetch);
        int unsigned fetches;
        if (new_size) write_size(size);
        if (rewind) send_word(CMD_REWIND, 16'($urandom()));
        repeat (n_loads) begin
            maybe_noise();
            send_word(CMD_LOAD, pick_sample(sb.columns()));
        end
        fetches = whole_file ? sb.bytes_left() + $urandom_range(1, 3) : n_fetch;
        repeat (fetches) begin
            maybe_noise();
            fetch_byte();
        end
    endtask

    initial begin
        logic [N_W-1:0] size;
        int unsigned n;
        sb = new();
        words_sent = 0;
        burst = 1'b0;
        with_noise = 1'b0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_word <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Header bytes at the reset size, an unused command, then a tiny image.
        repeat (3) send_word(CMD_FETCH, 16'hffff);
        send_word(CMD_NONE, 16'h0000);
        write_size(11'd4);
        send_word(CMD_REWIND, 16'h0000);
        send_word(CMD_LOAD, 16'hfffe);
        send_word(CMD_LOAD, 16'h0001);
        send_word(CMD_LOAD, 16'h7fff);
        send_word(CMD_LOAD, 16'h8000);
        send_word(CMD_LOAD, 16'h5555);
        repeat (4) send_word(CMD_FETCH, 16'h0000);
        send_word(CMD_REWIND, 16'hffff);
        repeat (2) send_word(CMD_FETCH, 16'h8000);
        send_word(CMD_NONE, 16'hffff);

        // Largest image once: saturated size, every column loaded, first pixel bytes read.
        burst = 1'b1;
        run_phase(11'h7ff, 1'b1, 1'b1, MAX_COLUMNS, 1'b0, HDR_BYTES + 8);

        burst = 1'b0;
        with_noise = 1'b1;
        run_phase(11'd0, 1'b1, 1'b1, 2, 1'b1, 0);
        run_phase(11'd1, 1'b1, 1'b1, 2, 1'b1, 0);
        run_phase(11'd32, 1'b1, 1'b1, 32, 1'b0, 70);
        burst = 1'b1;
        run_phase(11'd33, 1'b1, 1'b1, 34, 1'b0, 80);
        burst = 1'b0;
        run_phase(11'd20, 1'b1, 1'b1, 20, 1'b0, 40);
        run_phase(11'd9, 1'b1, 1'b0, 0, 1'b0, 40);

        while (words_sent < RANDOM_WORDS) begin
            case ($urandom_range(0, 9))
                0: size = 11'd0;
                1, 2: size = 11'($urandom_range(33, 64));
                default: size = 11'($urandom_range(1, 32));
            endcase
            n = size;
            burst = ($urandom_range(0, 3) == 0);
            with_noise = ($urandom_range(0, 3) != 0);
            run_phase(size, $urandom_range(0, 3) != 0, $urandom_range(0, 7) != 0,
                      n + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0),
                      $urandom_range(0, 2) != 0, $urandom_range(1, 120));
        end

        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d bytes never returned", sb.pending()));
        if (sb.mismatch_count == 0) begin
            $display("waveform_to_mono_bmp_raster verification clean");
        end else begin
            $display("waveform_to_mono_bmp_raster verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/wav_pkg.sv
rtl/wav_div.sv
rtl/waveform_to_mono_bmp_raster.sv
rtl/wav_chk.sv
sim/tb_waveform_to_mono_bmp_raster.sv
